@@ rtl/fpidw_pkg.sv @@
package fpidw_pkg;

  localparam int PIX_W    = 6;
  localparam int PIX_N    = 1 << PIX_W;
  localparam int COORD_W  = 16;
  localparam int Q_W      = 32;
  localparam int PAIR_W   = 2 * Q_W;
  localparam int WGT_W    = 3 * Q_W;
  localparam int CH_W     = 8;
  localparam int CH_N     = 3;
  localparam int PT_N     = 4;
  localparam int COLOR_W  = CH_N * CH_W;
  localparam int POINT_W  = 2 * COORD_W;
  localparam int CFG_W    = POINT_W;
  localparam int CFG_IDX_W = 3;
  localparam int WSUM_W   = WGT_W + 2;
  localparam int ACC_W    = WSUM_W + CH_W;
  localparam int DIV_W    = ACC_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_A = 3'd0,
    REG_COLOR_B = 3'd1,
    REG_COLOR_C = 3'd2,
    REG_COLOR_D = 3'd3,
    REG_POINT_A = 3'd4,
    REG_POINT_B = 3'd5,
    REG_POINT_C = 3'd6,
    REG_POINT_D = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PT_N-1:0][COLOR_W-1:0] color;
    logic [PT_N-1:0][POINT_W-1:0] point;
  } cfg_t;

endpackage

@@ rtl/four_point_idw_gradient_pixel_core.sv @@
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_data (pixel_x, pixel_y)
// out     | output    | out_valid, out_ready, out_data (red, green, blue)
// cfg     | input     | cfg_we, cfg_addr, cfg_wdata (write only)
//
// One pixel per clock sustained while the output is not stalled; the path from
// input transfer to output valid has 4 distance, 6 weight and 9 divider stages.
// The 8-bit restoring divider, one quotient bit per stage after the first, sets the depth.
// Reset clears the color and point registers and all stage valid bits.
// Each stage loads when empty or when the next stage moves, so bubbles
// close up and input transfers continue while a result waits at the output.
module four_point_idw_gradient_pixel_core #(
  parameter int GRID_SIZE = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fpidw_pkg::pix_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fpidw_pkg::rgb_t                  out_data,
  input  logic                             cfg_we,
  input  logic [fpidw_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [fpidw_pkg::CFG_W-1:0]      cfg_wdata
);

  fpidw_pkg::cfg_t cfg;

  logic q_valid, q_ready;
  logic [fpidw_pkg::PT_N-1:0][fpidw_pkg::Q_W-1:0] q_data;
  logic s_valid, s_ready;
  logic [fpidw_pkg::WSUM_W-1:0] s_wsum;
  logic [fpidw_pkg::CH_N-1:0][fpidw_pkg::ACC_W-1:0] s_acc;

  fpidw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpidw_dist #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  fpidw_weight u_weight (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_wsum  (s_wsum),
    .s_acc   (s_acc)
  );

  fpidw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_wsum    (s_wsum),
    .s_acc     (s_acc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/fpidw_cfg.sv @@
module fpidw_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fpidw_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [fpidw_pkg::CFG_W-1:0]         cfg_wdata,
  output fpidw_pkg::cfg_t                     cfg
);

  fpidw_pkg::cfg_t cfg_r;
  fpidw_pkg::cfg_t cfg_nxt;

  // Decode the register index and update the addressed field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (fpidw_pkg::cfg_idx_t'(cfg_addr))
        fpidw_pkg::REG_COLOR_A: cfg_nxt.color[0] = cfg_wdata[fpidw_pkg::COLOR_W-1:0];
        fpidw_pkg::REG_COLOR_B: cfg_nxt.color[1] = cfg_wdata[fpidw_pkg::COLOR_W-1:0];
        fpidw_pkg::REG_COLOR_C: cfg_nxt.color[2] = cfg_wdata[fpidw_pkg::COLOR_W-1:0];
        fpidw_pkg::REG_COLOR_D: cfg_nxt.color[3] = cfg_wdata[fpidw_pkg::COLOR_W-1:0];
        fpidw_pkg::REG_POINT_A: cfg_nxt.point[0] = cfg_wdata;
        fpidw_pkg::REG_POINT_B: cfg_nxt.point[1] = cfg_wdata;
        fpidw_pkg::REG_POINT_C: cfg_nxt.point[2] = cfg_wdata;
        fpidw_pkg::REG_POINT_D: cfg_nxt.point[3] = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/fpidw_dist.sv @@
module fpidw_dist #(
  parameter int GRID_SIZE = 64
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  fpidw_pkg::cfg_t                             cfg,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  fpidw_pkg::pix_t                             in_data,
  output logic                                        q_valid,
  input  logic                                        q_ready,
  output logic [fpidw_pkg::PT_N-1:0][fpidw_pkg::Q_W-1:0] q_data
);

  localparam int C_W = fpidw_pkg::COORD_W;
  localparam int Q_W = fpidw_pkg::Q_W;
  localparam int PT_N = fpidw_pkg::PT_N;
  localparam int DEN = (GRID_SIZE > 2) ? (GRID_SIZE - 1) : 1;
  localparam longint unsigned CMAX = (64'd1 << C_W) - 64'd1;

  // Coordinate table: round half up of p / (GRID_SIZE - 1) in Q0.16, saturated
  logic [C_W-1:0] coord_tab [fpidw_pkg::PIX_N];

  for (genvar p = 0; p < fpidw_pkg::PIX_N; p++) begin : g_tab
    localparam longint unsigned RAW =
      (longint'(p) * (64'd1 << C_W) + longint'(DEN / 2)) / longint'(DEN);
    localparam logic [C_W-1:0] CV = (RAW > CMAX) ? {C_W{1'b1}} : C_W'(RAW);
    assign coord_tab[p] = CV;
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  logic [C_W-1:0] nx_r, ny_r;
  logic [PT_N-1:0][Q_W-1:0] sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [PT_N-1:0][Q_W-1:0] d2_r, d2_nxt;
  logic [PT_N-1:0][Q_W-1:0] q_r, q_nxt;

  // Stage ready chain: a stage loads when empty or when its successor moves
  assign adv4 = !v4_r || q_ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;

  for (genvar i = 0; i < PT_N; i++) begin : g_pt
    logic [C_W-1:0]   px, py, dx, dy;
    logic [Q_W:0]     sum;
    logic [2*Q_W-1:0] prod;

    // Absolute offsets and their squares
    always_comb begin
      px = cfg.point[i][2*C_W-1:C_W];
      py = cfg.point[i][C_W-1:0];
      dx = (nx_r >= px) ? (nx_r - px) : (px - nx_r);
      dy = (ny_r >= py) ? (ny_r - py) : (py - ny_r);
      sqx_nxt[i] = dx * dx;
      sqy_nxt[i] = dy * dy;
    end

    // Squared distance, saturated to Q0.32
    always_comb begin
      sum = {1'b0, sqx_r[i]} + {1'b0, sqy_r[i]};
      d2_nxt[i] = sum[Q_W] ? {Q_W{1'b1}} : sum[Q_W-1:0];
    end

    // Quartic distance, upper half kept, clamped to at least one unit
    always_comb begin
      prod = d2_r[i] * d2_r[i];
      q_nxt[i] = (prod[2*Q_W-1:Q_W] == '0) ? Q_W'(1) : prod[2*Q_W-1:Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      nx_r <= coord_tab[in_data.pixel_x];
      ny_r <= coord_tab[in_data.pixel_y];
    end
    if (adv2) begin
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
    end
    if (adv3) d2_r <= d2_nxt;
    if (adv4) q_r <= q_nxt;
  end

  assign q_valid = v4_r;
  assign q_data  = q_r;

endmodule

@@ rtl/fpidw_weight.sv @@
module fpidw_weight (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  fpidw_pkg::cfg_t                                     cfg,
  input  logic                                                q_valid,
  output logic                                                q_ready,
  input  logic [fpidw_pkg::PT_N-1:0][fpidw_pkg::Q_W-1:0]      q_data,
  output logic                                                s_valid,
  input  logic                                                s_ready,
  output logic [fpidw_pkg::WSUM_W-1:0]                        s_wsum,
  output logic [fpidw_pkg::CH_N-1:0][fpidw_pkg::ACC_W-1:0]    s_acc
);

  localparam int Q_W    = fpidw_pkg::Q_W;
  localparam int PAIR_W = fpidw_pkg::PAIR_W;
  localparam int WGT_W  = fpidw_pkg::WGT_W;
  localparam int CH_W   = fpidw_pkg::CH_W;
  localparam int CH_N   = fpidw_pkg::CH_N;
  localparam int PT_N   = fpidw_pkg::PT_N;
  localparam int CP_W   = WGT_W + CH_W;
  localparam int WSUM_W = fpidw_pkg::WSUM_W;
  localparam int ACC_W  = fpidw_pkg::ACC_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  logic [PT_N-1:0][PAIR_W-1:0] pair_r, pair_nxt;
  logic [PT_N-1:0][Q_W-1:0]    ql_r, ql_nxt;
  logic [PT_N-1:0][PAIR_W-1:0] plo_r, phi_r, plo_nxt, phi_nxt;
  logic [PT_N-1:0][WGT_W-1:0]  w_r, w_nxt;
  logic [CH_N-1:0][PT_N-1:0][CP_W-1:0] cp_r, cp_nxt;
  logic [1:0][WGT_W:0]         ws_half_r, ws_half_nxt;
  logic [CH_N-1:0][1:0][CP_W:0] acc_half_r, acc_half_nxt;
  logic [WSUM_W-1:0]           wsum5_r, wsum6_r, wsum_nxt;
  logic [CH_N-1:0][ACC_W-1:0]  acc_r, acc_nxt;

  assign adv6 = !v6_r || s_ready;
  assign adv5 = !v5_r || adv6;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign q_ready = adv1;

  for (genvar i = 0; i < PT_N; i++) begin : g_pt
    localparam int J = (i + 1) % PT_N;
    localparam int K = (i + 2) % PT_N;
    localparam int L = (i + 3) % PT_N;

    // Product of two other quartics; carry the third along
    assign pair_nxt[i] = q_data[J] * q_data[K];
    assign ql_nxt[i]   = q_data[L];

    // Split the 64 by 32 product into two 32 by 32 halves
    assign plo_nxt[i] = pair_r[i][Q_W-1:0] * ql_r[i];
    assign phi_nxt[i] = pair_r[i][PAIR_W-1:Q_W] * ql_r[i];

    // Recombine the halves into the full weight
    assign w_nxt[i] = {phi_r[i], {Q_W{1'b0}}} + WGT_W'(plo_r[i]);

    // Weight times each channel of the matching color
    for (genvar ch = 0; ch < CH_N; ch++) begin : g_ch
      assign cp_nxt[ch][i] =
        w_r[i] * cfg.color[i][(CH_N-ch)*CH_W-1 -: CH_W];
    end
  end

  // Adder trees for the weight sum and the channel sums
  always_comb begin
    ws_half_nxt[0] = {1'b0, w_r[0]} + {1'b0, w_r[1]};
    ws_half_nxt[1] = {1'b0, w_r[2]} + {1'b0, w_r[3]};
    wsum_nxt = {1'b0, ws_half_r[0]} + {1'b0, ws_half_r[1]};
    for (int ch = 0; ch < CH_N; ch++) begin
      acc_half_nxt[ch][0] = {1'b0, cp_r[ch][0]} + {1'b0, cp_r[ch][1]};
      acc_half_nxt[ch][1] = {1'b0, cp_r[ch][2]} + {1'b0, cp_r[ch][3]};
      acc_nxt[ch] = {1'b0, acc_half_r[ch][0]} + {1'b0, acc_half_r[ch][1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= q_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      pair_r <= pair_nxt;
      ql_r   <= ql_nxt;
    end
    if (adv2) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (adv3) w_r <= w_nxt;
    if (adv4) begin
      cp_r      <= cp_nxt;
      ws_half_r <= ws_half_nxt;
    end
    if (adv5) begin
      acc_half_r <= acc_half_nxt;
      wsum5_r    <= wsum_nxt;
    end
    if (adv6) begin
      acc_r   <= acc_nxt;
      wsum6_r <= wsum5_r;
    end
  end

  assign s_valid = v6_r;
  assign s_wsum  = wsum6_r;
  assign s_acc   = acc_r;

endmodule

@@ rtl/fpidw_div.sv @@
module fpidw_div (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                s_valid,
  output logic                                                s_ready,
  input  logic [fpidw_pkg::WSUM_W-1:0]                        s_wsum,
  input  logic [fpidw_pkg::CH_N-1:0][fpidw_pkg::ACC_W-1:0]    s_acc,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output fpidw_pkg::rgb_t                                     out_data
);

  localparam int DIV_W  = fpidw_pkg::DIV_W;
  localparam int CH_W   = fpidw_pkg::CH_W;
  localparam int CH_N   = fpidw_pkg::CH_N;
  localparam int NST    = CH_W + 1;

  // Stage 0 forms the rounded target; stages 1..8 each settle one quotient bit
  logic [NST-1:0]                     v_r;
  logic [NST-1:0]                     adv;
  logic [NST-1:0][DIV_W-1:0]          den2_r;
  logic [NST-1:0][CH_N-1:0][DIV_W-1:0] rem_r;
  logic [NST-1:0][CH_N-1:0][CH_W-1:0]  quo_r;

  assign adv[NST-1] = !v_r[NST-1] || out_ready;
  for (genvar s = 0; s < NST - 1; s++) begin : g_adv
    assign adv[s] = !v_r[s] || adv[s+1];
  end
  assign s_ready = adv[0];

  // Twice the denominator and twice the numerator plus the denominator
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      den2_r[0] <= DIV_W'({s_wsum, 1'b0});
      for (int ch = 0; ch < CH_N; ch++) begin
        rem_r[0][ch] <= DIV_W'({s_acc[ch], 1'b0}) + DIV_W'(s_wsum);
        quo_r[0][ch] <= '0;
      end
    end
  end

  for (genvar s = 1; s < NST; s++) begin : g_st
    localparam int B = NST - 1 - s;
    logic [DIV_W-1:0]            shd;
    logic [CH_N-1:0][DIV_W-1:0]  rem_nxt;
    logic [CH_N-1:0][CH_W-1:0]   quo_nxt;

    // Restoring step: subtract the shifted divisor where it fits
    always_comb begin
      shd = den2_r[s-1] << B;
      for (int ch = 0; ch < CH_N; ch++) begin
        if (rem_r[s-1][ch] >= shd) begin
          rem_nxt[ch] = rem_r[s-1][ch] - shd;
          quo_nxt[ch] = quo_r[s-1][ch] | (CH_W'(1) << B);
        end else begin
          rem_nxt[ch] = rem_r[s-1][ch];
          quo_nxt[ch] = quo_r[s-1][ch];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        den2_r[s] <= den2_r[s-1];
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= s_valid;
      for (int s = 1; s < NST; s++) begin
        if (adv[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  assign out_valid      = v_r[NST-1];
  assign out_data.red   = quo_r[NST-1][0];
  assign out_data.green = quo_r[NST-1][1];
  assign out_data.blue  = quo_r[NST-1][2];

endmodule

@@ tb/four_point_idw_gradient_pixel_core_test.sv @@
module four_point_idw_gradient_pixel_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpidw_pkg::*;

  localparam int GRID = 64;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 100;

  // Blended pixel color predictor with its own register copy
  class pixel_color_board;
    logic [COLOR_W-1:0] color[PT_N];
    logic [POINT_W-1:0] point[PT_N];
    rgb_t expected_colors[$];
    int mismatches;
    int colors_checked;

    function new();
      for (int i = 0; i < PT_N; i++) begin
        color[i] = '0;
        point[i] = '0;
      end
      mismatches = 0;
      colors_checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx <= REG_COLOR_D) color[idx] = value[COLOR_W-1:0];
      else point[idx - REG_POINT_A] = value;
    endfunction

    // Grid position to Q0.16, rounded half up, saturating at the edge
    function logic [63:0] grid_coord(logic [PIX_W-1:0] p);
      logic [63:0] v;
      v = ({58'd0, p} * 64'd65536 + (GRID - 1) / 2) / (GRID - 1);
      return (v > 64'd65535) ? 64'd65535 : v;
    endfunction

    // Squared distance squared, Q0.32, clamped to at least one unit
    function logic [63:0] quartic_dist(logic [63:0] nx, logic [63:0] ny,
                                       logic [POINT_W-1:0] pt);
      logic [63:0] px, py, dx, dy, d2, q;
      px = {48'd0, pt[31:16]};
      py = {48'd0, pt[15:0]};
      dx = (nx >= px) ? nx - px : px - nx;
      dy = (ny >= py) ? ny - py : py - ny;
      d2 = dx * dx + dy * dy;
      if (d2 > 64'hFFFF_FFFF) d2 = 64'hFFFF_FFFF;
      q = (d2 * d2) >> 32;
      return (q < 64'd1) ? 64'd1 : q;
    endfunction

    function rgb_t blend(pix_t p);
      logic [63:0] nx, ny;
      logic [127:0] q[PT_N];
      logic [127:0] w[PT_N];
      logic [127:0] wsum, acc, target, twice_den;
      logic [7:0] quo, t;
      logic [7:0] chan[CH_N];
      rgb_t r;
      nx = grid_coord(p.pixel_x);
      ny = grid_coord(p.pixel_y);
      for (int i = 0; i < PT_N; i++) q[i] = {64'd0, quartic_dist(nx, ny, point[i])};
      wsum = '0;
      for (int i = 0; i < PT_N; i++) begin
        w[i] = q[(i + 1) % 4] * q[(i + 2) % 4] * q[(i + 3) % 4];
        wsum = wsum + w[i];
      end
      twice_den = wsum << 1;
      for (int ch = 0; ch < CH_N; ch++) begin
        acc = '0;
        for (int i = 0; i < PT_N; i++)
          acc = acc + w[i] * {120'd0, color[i][(16 - 8 * ch) +: 8]};
        target = (acc << 1) + wsum;
        quo = '0;
        // Restoring search, one quotient bit per pass
        for (int b = 7; b >= 0; b--) begin
          t = quo | (8'd1 << b);
          if (twice_den * {120'd0, t} <= target) quo = t;
        end
        chan[ch] = quo;
      end
      r.red = chan[0];
      r.green = chan[1];
      r.blue = chan[2];
      return r;
    endfunction

    function void note_pixel(pix_t p);
      expected_colors.push_back(blend(p));
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_color(rgb_t got);
      rgb_t want;
      colors_checked++;
      if (expected_colors.size() == 0) begin
        report($sformatf("unexpected color %h", got));
        return;
      end
      want = expected_colors.pop_front();
      if (got.red !== want.red)
        report($sformatf("red %h, expected %h", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green %h, expected %h", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue %h, expected %h", got.blue, want.blue));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pix_t in_data;
  logic out_valid;
  logic out_ready;
  rgb_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  pixel_color_board board = new();
  bit no_stall;
  int pixels_sent;
  int settings_used;

  four_point_idw_gradient_pixel_core #(.GRID_SIZE(GRID)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_color(out_data);
  end

  // Receiver: random stall before each transfer
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Send one pixel after a random gap; valid stays high across back-to-back items
  task send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int gap;
    pix_t p;
    p.pixel_x = px;
    p.pixel_y = py;
    gap = no_stall ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(p);
    pixels_sent++;
  endtask

  // Drain the pipeline, then load all eight registers
  task load_settings(logic [COLOR_W-1:0] ca, logic [COLOR_W-1:0] cb,
                     logic [COLOR_W-1:0] cc, logic [COLOR_W-1:0] cd,
                     logic [POINT_W-1:0] pa, logic [POINT_W-1:0] pb,
                     logic [POINT_W-1:0] pc, logic [POINT_W-1:0] pd);
    logic [CFG_W-1:0] vals[8];
    cfg_idx_t idx;
    vals = '{CFG_W'(ca), CFG_W'(cb), CFG_W'(cc), CFG_W'(cd), pa, pb, pc, pd};
    in_valid <= 1'b0;
    while (board.expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_t'(i);
      cfg_we <= 1'b1;
      cfg_addr <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.set_reg(idx, vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function logic [POINT_W-1:0] grid_point(int gx, int gy);
    logic [63:0] cx, cy;
    cx = board.grid_coord(gx[PIX_W-1:0]);
    cy = board.grid_coord(gy[PIX_W-1:0]);
    return {cx[15:0], cy[15:0]};
  endfunction

  initial begin
    int n;
    int rx, ry;
    logic [POINT_W-1:0] pts[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    no_stall = 1'b0;
    pixels_sent = 0;
    settings_used = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all points coincide, all colors black
    send_pixel(0, 0);
    send_pixel(63, 63);
    send_pixel(21, 42);

    // Primary colors and white in the corners; hit each corner and the center
    load_settings(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
                  32'h0000_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFF);
    send_pixel(0, 0);
    send_pixel(63, 0);
    send_pixel(0, 63);
    send_pixel(63, 63);
    send_pixel(31, 32);
    send_pixel(62, 1);
    send_pixel(1, 62);
    send_pixel(42, 21);

    // All registers at their maximum: all four points on the same far corner
    load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(0, 0);
    send_pixel(63, 63);
    send_pixel(32, 31);

    // Control points on grid pixels: exact hits and ties between points
    load_settings(24'h123456, 24'h80FF01, 24'hFE7F00, 24'h00AA55,
                  grid_point(10, 10), grid_point(50, 10),
                  grid_point(10, 50), grid_point(50, 50));
    send_pixel(10, 10);
    send_pixel(50, 10);
    send_pixel(10, 50);
    send_pixel(50, 50);
    send_pixel(30, 30);
    send_pixel(30, 10);
    send_pixel(0, 63);

    // Random phases; the first runs without any idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 2))
          0: pts[i] = $urandom();
          1: pts[i] = grid_point($urandom_range(0, 63), $urandom_range(0, 63));
          default: pts[i] = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                             $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
        endcase
      end
      if (ph == RANDOM_PHASES - 1)
        load_settings(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                      pts[0], pts[1], pts[2], pts[3]);
      else
        load_settings(COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                      COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                      COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                      COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                      pts[0], pts[1], pts[2], pts[3]);
      no_stall = (ph == 0);
      n = 0;
      while (n < PHASE_ITEMS) begin
        rx = $urandom_range(0, 63);
        ry = $urandom_range(0, 63);
        send_pixel(rx[PIX_W-1:0], ry[PIX_W-1:0]);
        n++;
      end
      no_stall = 1'b0;
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (board.expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.expected_colors.size() != 0)
      board.report("colors still outstanding at end of run");
    $display("Blended %0d pixels under %0d register settings, %0d colors checked.",
             pixels_sent, settings_used + 1, board.colors_checked);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
